// ===== hdl/glzw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Shared constants, channel payload types and the code transaction type that
// moves from the dictionary front end to the bit packer.
// ----------------------------------------------------------------------------
package glzw_pkg;

   localparam int ROOT_BITS   = 8;
   localparam int BYTE_BITS   = 8;
   localparam int CODE_W      = 12;
   localparam int WIDTH_W     = 4;
   localparam int CMP_W       = 13;
   localparam int ACC_W       = 19;
   localparam int CNT_W       = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int FIRST_FREE  = 258;

   localparam logic [CODE_W-1:0]  CLEAR_CODE  = 12'd256;
   localparam logic [WIDTH_W-1:0] START_WIDTH = 4'd9;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH   = 4'd12;

   typedef struct packed {
      logic [ROOT_BITS-1:0] pixel;
      logic                 last_pixel;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] code_byte;
      logic                 stream_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0]  code;
      logic [WIDTH_W-1:0] width;
      logic               last;
   } code_op_type;

endpackage

// ===== hdl/glzw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module glzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/glzw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW dictionary front end
// Accepts pixels, looks up the prefix and pixel pair, updates the dictionary
// and pushes the codes to be written into the code queue.
// ----------------------------------------------------------------------------
module glzw_front import glzw_pkg::*; #(
   parameter int CODE_LIMIT = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            op_valid,
   output code_op_type     op,
   input  logic            op_full
);

   localparam int CODE_BITS  = $clog2(CODE_LIMIT);
   localparam int NF_W       = CODE_BITS + 1;
   localparam int ADDR_W     = CODE_BITS + ROOT_BITS;
   localparam int DICT_DEPTH = CODE_LIMIT * (2 ** ROOT_BITS);

   localparam logic [NF_W-1:0]      LIMIT_NF   = NF_W'(CODE_LIMIT);
   localparam logic [NF_W-1:0]      FREE_NF    = NF_W'(FIRST_FREE);
   localparam logic [CODE_BITS-1:0] FREE_CODE  = CODE_BITS'(FIRST_FREE);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LOOK1,
      ST_LOOK2,
      ST_MISS_PREFIX,
      ST_MISS_CLEAR,
      ST_LAST
   } state_type;

   state_type             state_ff, state_in;
   logic [CODE_BITS-1:0]  prefix_ff, prefix_in;
   logic [NF_W-1:0]       nf_ff, nf_in;
   logic [WIDTH_W-1:0]    width_ff, width_in;
   logic                  first_seen_ff, first_seen_in;
   logic [ROOT_BITS-1:0]  pixel_ff, pixel_in;
   logic                  last_ff, last_in;

   logic [ADDR_W-1:0]     dict_raddr;
   logic [ADDR_W-1:0]     lookup_addr;
   logic [CODE_BITS-1:0]  dict_rdata;
   logic [ADDR_W-1:0]     rev_rdata;
   logic                  dict_we;
   logic                  hit;
   logic                  can_add;
   logic                  grow;
   logic [NF_W-1:0]       nf_inc;

   assign lookup_addr = {prefix_ff, pixel_ff};
   assign dict_raddr  = {prefix_ff, (state_ff == ST_IDLE) ? req_payload.pixel : pixel_ff};

   assign hit = (dict_rdata >= FREE_CODE) && (NF_W'(dict_rdata) < nf_ff)
                && (rev_rdata == lookup_addr);
   assign can_add = nf_ff < LIMIT_NF;
   assign nf_inc  = nf_ff + 1'b1;
   assign grow    = ((CMP_W'(1) << width_ff) < CMP_W'(nf_inc)) && (nf_inc < LIMIT_NF)
                    && (width_ff < MAX_WIDTH);

   assign req_stall = state_ff != ST_IDLE;
   assign op_valid  = (state_ff == ST_FIRST) || (state_ff == ST_MISS_PREFIX)
                      || (state_ff == ST_MISS_CLEAR) || (state_ff == ST_LAST);
   assign dict_we   = (state_ff == ST_MISS_PREFIX) && !op_full && can_add;

   glzw_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (DICT_DEPTH)
   ) u_dict (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (lookup_addr),
      .wr_data (nf_ff[CODE_BITS-1:0]),
      .rd_addr (dict_raddr),
      .rd_data (dict_rdata)
   );

   // The reverse table holds, for every code, the pair that was given that code.
   glzw_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (CODE_LIMIT)
   ) u_rev (
      .clock   (clock),
      .wr_en   (dict_we),
      .wr_addr (nf_ff[CODE_BITS-1:0]),
      .wr_data (lookup_addr),
      .rd_addr (dict_rdata),
      .rd_data (rev_rdata)
   );

   always_comb begin
      op = '0;
      case (state_ff)
         ST_FIRST, ST_MISS_CLEAR: begin
            op.code  = CLEAR_CODE;
            op.width = width_ff;
         end
         ST_MISS_PREFIX: begin
            op.code  = CODE_W'(prefix_ff);
            op.width = width_ff;
         end
         ST_LAST: begin
            op.code  = CODE_W'(prefix_ff);
            op.width = width_ff;
            op.last  = 1'b1;
         end
         default: begin
            op = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      prefix_in     = prefix_ff;
      nf_in         = nf_ff;
      width_in      = width_ff;
      first_seen_in = first_seen_ff;
      pixel_in      = pixel_ff;
      last_in       = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pixel_in = req_payload.pixel;
               last_in  = req_payload.last_pixel;
               state_in = first_seen_ff ? ST_LOOK1 : ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (!op_full) begin
               prefix_in     = CODE_BITS'(pixel_ff);
               first_seen_in = 1'b1;
               state_in      = last_ff ? ST_LAST : ST_IDLE;
            end
         end
         ST_LOOK1: begin
            state_in = ST_LOOK2;
         end
         ST_LOOK2: begin
            if (hit) begin
               prefix_in = dict_rdata;
               state_in  = last_ff ? ST_LAST : ST_IDLE;
            end else begin
               state_in = ST_MISS_PREFIX;
            end
         end
         ST_MISS_PREFIX: begin
            if (!op_full) begin
               if (can_add) begin
                  nf_in     = nf_inc;
                  prefix_in = CODE_BITS'(pixel_ff);
                  state_in  = last_ff ? ST_LAST : ST_IDLE;
                  if (grow) begin
                     width_in = width_ff + 1'b1;
                  end
               end else begin
                  state_in = ST_MISS_CLEAR;
               end
            end
         end
         ST_MISS_CLEAR: begin
            if (!op_full) begin
               nf_in     = FREE_NF;
               width_in  = START_WIDTH;
               prefix_in = CODE_BITS'(pixel_ff);
               state_in  = last_ff ? ST_LAST : ST_IDLE;
            end
         end
         ST_LAST: begin
            if (!op_full) begin
               prefix_in     = '0;
               nf_in         = FREE_NF;
               width_in      = START_WIDTH;
               first_seen_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prefix_ff     <= '0;
         nf_ff         <= FREE_NF;
         width_ff      <= START_WIDTH;
         first_seen_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prefix_ff     <= prefix_in;
         nf_ff         <= nf_in;
         width_ff      <= width_in;
         first_seen_ff <= first_seen_in;
      end
      pixel_ff <= pixel_in;
      last_ff  <= last_in;
   end

`ifndef ASSERT_OFF
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= START_WIDTH) && (width_ff <= MAX_WIDTH))
      else $error("Code width left the nine to twelve bit range.");

   a_free_range: assert property (@(posedge clock) disable iff (reset)
      (nf_ff >= FREE_NF) && (nf_ff <= LIMIT_NF))
      else $error("Next free code left its legal range.");

   a_write_below_limit: assert property (@(posedge clock) disable iff (reset)
      dict_we |=> (nf_ff == $past(nf_ff) + 1'b1))
      else $error("A dictionary write did not advance the next free code.");
`endif

endmodule

// ===== hdl/glzw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW code queue
// Short first-in first-out buffer of code transactions between the dictionary
// front end and the bit packer.
// ----------------------------------------------------------------------------
module glzw_queue import glzw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   input  code_op_type push_data,
   output logic        full,
   output logic        pop_valid,
   output code_op_type pop_data,
   input  logic        pop_take
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   code_op_type      entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push;
   logic             pop;

   assign full      = count_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_take && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(QUEUE_DEPTH))
      else $error("Code queue holds more transactions than its depth.");
`endif

endmodule

// ===== hdl/glzw_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GIF LZW bit packer
// Appends codes least significant bit first to the pending bits and hands out one
// byte per cycle while not stalled, padding the final partial byte of an image.
// ----------------------------------------------------------------------------
module glzw_packer import glzw_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  code_op_type     op,
   output logic            op_take,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam logic [CNT_W-1:0] BYTE_CNT  = CNT_W'(BYTE_BITS);
   localparam logic [ACC_W-1:0] PEND_MASK = ACC_W'(7'h7F);

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             end_ff, end_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic             emit_possible;
   logic             emit;
   logic             end_byte;

   assign emit_possible = (cnt_ff >= BYTE_CNT) || (end_ff && (cnt_ff != '0));
   assign emit          = emit_possible && (!rsp_valid_ff || !rsp_stall);
   assign end_byte      = end_ff && (cnt_ff <= BYTE_CNT);
   assign op_take       = !emit_possible && op_valid;

   always_comb begin
      acc_in         = acc_ff;
      cnt_in         = cnt_ff;
      end_in         = end_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = emit || (rsp_valid_ff && rsp_stall);
      if (emit) begin
         rsp_payload_in.code_byte  = acc_ff[BYTE_BITS-1:0];
         rsp_payload_in.stream_end = end_byte;
         acc_in = acc_ff >> BYTE_BITS;
         cnt_in = (cnt_ff >= BYTE_CNT) ? cnt_ff - BYTE_CNT : '0;
         if (end_byte) begin
            acc_in = '0;
            end_in = 1'b0;
         end else if (cnt_in < BYTE_CNT) begin
            acc_in = acc_in & PEND_MASK;
         end
      end else if (op_take) begin
         acc_in = acc_ff | (ACC_W'(op.code) << cnt_ff);
         cnt_in = cnt_ff + CNT_W'(op.width);
         end_in = op.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_end_drains: assert property (@(posedge clock) disable iff (reset)
      (emit && end_byte) |=> ((cnt_ff == '0) && !end_ff && (acc_ff == '0)))
      else $error("Bits remain pending after the final byte of an image.");

   a_no_take_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (op_take |-> (cnt_ff < BYTE_CNT) && !end_ff))
      else $error("A code was taken while a full byte was still pending.");
`endif

endmodule

// ===== hdl/gif_lzw_code_stream_encoder.sv =====
`timescale 1ns / 1ps
// Pixel flow: the first pixel of an image pushes a clear code; any other pixel takes a
// dictionary read, then a dependent reverse table read, and on a miss pushes its prefix
// code (and a clear code when the code limit forces a clear); the last pixel then also
// pushes the final code. Codes go one per cycle into a 4-entry code queue while it is
// not full. The packer hands out one byte per cycle while its output is not stalled.
// Reset is synchronous; the dictionary needs no clearing pass after reset or a clear.
// ----------------------------------------------------------------------------
// GIF LZW code stream encoder
// Top level: dictionary front end, code queue and bit packer in series.
// ----------------------------------------------------------------------------
module gif_lzw_code_stream_encoder import glzw_pkg::*; #(
   parameter int CODE_LIMIT = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic        front_valid;
   code_op_type front_op;
   logic        queue_full;
   logic        queue_valid;
   code_op_type queue_op;
   logic        packer_take;

   glzw_front #(
      .CODE_LIMIT (CODE_LIMIT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .op_valid    (front_valid),
      .op          (front_op),
      .op_full     (queue_full)
   );

   glzw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_op),
      .full       (queue_full),
      .pop_valid  (queue_valid),
      .pop_data   (queue_op),
      .pop_take   (packer_take)
   );

   glzw_packer u_packer (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (queue_valid),
      .op          (queue_op),
      .op_take     (packer_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
